@@ hw/rtl/tclb_pkg.sv @@
// Command codes and character constants for the text console line buffer.
package tclb_pkg;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [7:0] CODE_CR = 8'd13;
  localparam logic [7:0] CODE_LF = 8'd10;

endpackage

@@ hw/rtl/text_console_line_buffer_core.sv @@
// Text console line buffer: character store, per-row lengths and cursor.
//
// Character store of a scrolling text console. A command is transferred
// when start is high and busy is low. Every command returns exactly one
// result. The result is shown on cell_code, cursor_row, cursor_col and
// dropped for one cycle, marked by done. The receiver cannot stall it and
// must take it in that cycle. For put, clear and the unused code, busy
// stays low and the result appears in the cycle after the transfer, so
// one command can follow another in every cycle. For a read, busy is high
// in the cycle after the transfer and the result follows in the cycle
// after that, because the cell memory and the row-length memory both have
// registered read ports that the read must wait for. Rows are kept in a
// circular store with a top-row pointer, so a scroll moves the pointer and
// copies nothing. Each row stores its length in a small memory and has a
// valid bit in flip-flops. A row whose valid bit is clear has length zero,
// so clear and line feed empty rows at once and need no sweep. No clearing
// pass runs after reset. Cells at or beyond a row's length read as zero.
// A character put on a full row is dropped, and dropped is raised for it.
module text_console_line_buffer_core
  import tclb_pkg::*;
#(
  parameter int ROWS = 32,
  parameter int COLS = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] command,
  input  logic [7:0] char_code,
  input  logic [4:0] read_row,
  input  logic [6:0] read_col,
  output logic       done,
  output logic [7:0] cell_code,
  output logic [4:0] cursor_row,
  output logic [7:0] cursor_col,
  output logic       dropped
);

  // Row index, length and cell-column widths.
  localparam int RW    = $clog2(ROWS);
  localparam int LW    = $clog2(COLS + 1);
  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int AW    = RW + CW;
  localparam int DEPTH = ROWS * (2 ** CW);
  // Widened forms for comparing the narrow input fields and masking outputs.
  localparam int SW    = ((RW > 5) ? RW : 5) + 1;
  localparam int XW    = (LW > 7) ? LW : 7;
  localparam int CXW   = (CW > 7) ? CW : 7;
  localparam int OXR   = (RW > 5) ? RW : 5;
  localparam int OXC   = (LW > 8) ? LW : 8;

  // Memories: cells addressed as {physical row, column}; row lengths.
  logic [7:0]    cell_mem [DEPTH];
  logic [LW-1:0] len_mem  [ROWS];
  logic [ROWS-1:0] row_valid;

  // Cursor and scroll state.
  logic [RW-1:0] top_row;
  logic [RW-1:0] cursor_line;
  logic [LW-1:0] cursor_column;
  logic [RW-1:0] top_row_next;
  logic [RW-1:0] cursor_line_next;
  logic [LW-1:0] cursor_column_next;

  // Read in flight: registered request and memory data.
  logic          read_pending;
  logic          rd_inrange;
  logic          rd_valid;
  logic [XW-1:0] rd_colx;
  logic [7:0]    cell_rdata;
  logic [LW-1:0] len_rdata;

  logic          accept;
  cmd_t          cmd;

  // Update controls for the current command.
  logic          cell_we;
  logic [AW-1:0] cell_waddr;
  logic          len_we;
  logic [RW-1:0] len_wrow;
  logic [LW-1:0] len_wdata;
  logic          clr_all;
  logic          clr_top;
  logic          clr_row;
  logic [RW-1:0] clr_row_idx;
  logic          drop;
  logic          rd_req;

  // Physical row of the cursor and the one after it.
  logic [RW:0]   cur_sum;
  logic [RW-1:0] cur_phys;
  logic [RW-1:0] cur_phys_inc;

  // Read address decode.
  logic [SW-1:0]  rrow_x;
  logic [SW-1:0]  rrow_sum;
  logic [XW-1:0]  rcol_x;
  logic [CXW-1:0] rcol_c;
  logic           rd_row_ok;
  logic           rd_col_ok;
  logic [RW-1:0]  rd_phys;
  logic [AW-1:0]  rd_addr;

  logic [OXR-1:0] row_out_x;
  logic [OXC-1:0] col_out_x;

  assign busy   = read_pending;
  assign accept = start && !read_pending;
  assign cmd    = cmd_t'(command);

  // Cursor row within the circular store; the sum stays below 2*ROWS.
  always_comb begin
    cur_sum = {1'b0, top_row} + {1'b0, cursor_line};
    if (cur_sum >= (RW + 1)'(ROWS)) begin
      cur_sum = cur_sum - (RW + 1)'(ROWS);
    end
    cur_phys = cur_sum[RW-1:0];
    cur_phys_inc = (cur_phys == RW'(ROWS - 1)) ? '0 : cur_phys + 1'b1;
  end

  // Read address: displayed row to physical row, range checks on both.
  always_comb begin
    rrow_x    = SW'(read_row);
    rd_row_ok = rrow_x < SW'(ROWS);
    rrow_sum  = SW'(top_row) + rrow_x;
    if (rrow_sum >= SW'(ROWS)) begin
      rrow_sum = rrow_sum - SW'(ROWS);
    end
    rd_phys   = rd_row_ok ? rrow_sum[RW-1:0] : '0;
    rcol_x    = XW'(read_col);
    rd_col_ok = rcol_x < XW'(COLS);
    rcol_c    = CXW'(read_col);
    rd_addr   = {rd_phys, (rd_col_ok ? rcol_c[CW-1:0] : CW'(0))};
  end

  // Command decode: next cursor state and memory/valid-bit updates.
  always_comb begin
    top_row_next       = top_row;
    cursor_line_next   = cursor_line;
    cursor_column_next = cursor_column;
    cell_we            = 1'b0;
    cell_waddr         = {cur_phys, cursor_column[CW-1:0]};
    len_we             = 1'b0;
    len_wrow           = cur_phys;
    len_wdata          = cursor_column + 1'b1;
    clr_all            = 1'b0;
    clr_top            = 1'b0;
    clr_row            = 1'b0;
    clr_row_idx        = cur_phys_inc;
    drop               = 1'b0;
    rd_req             = 1'b0;
    if (accept) begin
      case (cmd)
        CMD_PUT: begin
          if (char_code == CODE_LF) begin
            // New cursor row is always the physical row after the old one;
            // a scroll also empties the old top row, now the last shown.
            if (cursor_line == RW'(ROWS - 2)) begin
              clr_top      = 1'b1;
              top_row_next = (top_row == RW'(ROWS - 1)) ? '0 : top_row + 1'b1;
            end else begin
              cursor_line_next = cursor_line + 1'b1;
            end
            cursor_column_next = '0;
            clr_row            = 1'b1;
          end else if (char_code != CODE_CR) begin
            if (cursor_column < LW'(COLS)) begin
              cell_we            = 1'b1;
              len_we             = 1'b1;
              cursor_column_next = cursor_column + 1'b1;
            end else begin
              drop = 1'b1;
            end
          end
        end
        CMD_CLEAR: begin
          clr_all            = 1'b1;
          cursor_line_next   = '0;
          cursor_column_next = '0;
        end
        CMD_READ: begin
          rd_req = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Cell memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= char_code;
    end
    if (rd_req) begin
      cell_rdata <= cell_mem[rd_addr];
    end
  end

  // Row-length memory; a clear row is marked by its valid bit instead.
  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_wrow] <= len_wdata;
    end
    if (rd_req) begin
      len_rdata <= len_mem[rd_phys];
    end
  end

  // Read request payload held until the memory data is in.
  always_ff @(posedge clk) begin
    if (rd_req) begin
      rd_inrange <= rd_row_ok && rd_col_ok;
      rd_valid   <= row_valid[rd_phys];
      rd_colx    <= rcol_x;
    end
  end

  always_comb begin
    row_out_x = OXR'(cursor_line_next);
    col_out_x = OXC'(cursor_column_next);
  end

  // Control state, valid bits and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid     <= '0;
      top_row       <= '0;
      cursor_line   <= '0;
      cursor_column <= '0;
      read_pending  <= 1'b0;
      done          <= 1'b0;
      cell_code     <= '0;
      cursor_row    <= '0;
      cursor_col    <= '0;
      dropped       <= 1'b0;
    end else begin
      top_row       <= top_row_next;
      cursor_line   <= cursor_line_next;
      cursor_column <= cursor_column_next;

      if (clr_all) begin
        row_valid <= '0;
      end else begin
        if (len_we) begin
          row_valid[len_wrow] <= 1'b1;
        end
        if (clr_top) begin
          row_valid[top_row] <= 1'b0;
        end
        if (clr_row) begin
          row_valid[clr_row_idx] <= 1'b0;
        end
      end

      done <= 1'b0;
      if (read_pending) begin
        // Read pending: memory data is in, finish the result.
        read_pending <= 1'b0;
        done         <= 1'b1;
        cell_code    <= (rd_inrange && rd_valid && (rd_colx < XW'(len_rdata))) ?
                        cell_rdata : 8'd0;
      end else if (accept) begin
        cursor_row <= row_out_x[4:0];
        cursor_col <= col_out_x[7:0];
        dropped    <= drop;
        cell_code  <= 8'd0;
        if (rd_req) begin
          read_pending <= 1'b1;
        end else begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ bench/console_scoreboard_pkg.sv @@
// Scoreboard for the text console line buffer: predicted console state and result checks.
`timescale 1ns / 100ps

package console_scoreboard_pkg;
  import tclb_pkg::*;

  localparam int CON_ROWS = 32;
  localparam int CON_COLS = 128;

  typedef struct packed {
    logic [7:0] code;
    logic [4:0] row;
    logic [7:0] col;
    logic       lost;
  } console_result_t;

  class console_scoreboard;
    bit [7:0]        glyphs [CON_ROWS*CON_COLS];
    int unsigned     line_len [CON_ROWS];
    int unsigned     top_ptr;
    int unsigned     cur_line;
    int unsigned     cur_col;
    console_result_t pending [$];
    int              failures;

    function new();
      foreach (glyphs[i]) glyphs[i] = '0;
      foreach (line_len[i]) line_len[i] = 0;
      top_ptr  = 0;
      cur_line = 0;
      cur_col  = 0;
      failures = 0;
    endfunction

    function int unsigned phys_line(int unsigned shown);
      return (top_ptr + shown) % CON_ROWS;
    endfunction

    // Cursor down, or rotate the top pointer from the next-to-last row.
    function void advance_line();
      if (cur_line == CON_ROWS - 2) begin
        line_len[top_ptr] = 0;
        top_ptr = (top_ptr + 1) % CON_ROWS;
      end else begin
        cur_line = (cur_line + 1) % CON_ROWS;
      end
      cur_col = 0;
      line_len[phys_line(cur_line)] = 0;
    endfunction

    // Called on every accepted command transfer; queues the result it causes.
    function void note_command(cmd_t cmd, logic [7:0] code, logic [4:0] rrow,
                               logic [6:0] rcol);
      console_result_t want;
      int unsigned     p;
      want = '0;
      case (cmd)
        CMD_PUT: begin
          if (code == CODE_LF) begin
            advance_line();
          end else if (code != CODE_CR) begin
            if (cur_col < CON_COLS) begin
              p = phys_line(cur_line);
              glyphs[p*CON_COLS + cur_col] = code;
              cur_col++;
              line_len[p] = cur_col;
            end else begin
              want.lost = 1'b1;
            end
          end
        end
        CMD_CLEAR: begin
          foreach (line_len[i]) line_len[i] = 0;
          cur_line = 0;
          cur_col  = 0;
        end
        CMD_READ: begin
          if (rrow < CON_ROWS && rcol < CON_COLS) begin
            p = phys_line(rrow);
            if (rcol < line_len[p]) want.code = glyphs[p*CON_COLS + rcol];
          end
        end
        default: ;
      endcase
      want.row = cur_line[4:0];
      want.col = cur_col[7:0];
      pending.push_back(want);
    endfunction

    // Called on every done strobe.
    function void check_result(logic [7:0] code, logic [4:0] row, logic [7:0] col,
                               logic lost);
      console_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing pending: cell_code %0d cursor %0d/%0d dropped %b",
                 $time, code, row, col, lost);
        failures++;
        return;
      end
      want = pending.pop_front();
      if (code !== want.code) begin
        $display("%0t: cell_code expected %0d got %0d", $time, want.code, code);
        failures++;
      end
      if (row !== want.row) begin
        $display("%0t: cursor_row expected %0d got %0d", $time, want.row, row);
        failures++;
      end
      if (col !== want.col) begin
        $display("%0t: cursor_col expected %0d got %0d", $time, want.col, col);
        failures++;
      end
      if (lost !== want.lost) begin
        $display("%0t: dropped expected %b got %b", $time, want.lost, lost);
        failures++;
      end
    endfunction
  endclass

endpackage

@@ bench/tb_top.sv @@
// Top-level testbench for text_console_line_buffer_core: stimulus, monitor and end of run.
`timescale 1ns / 100ps

module tb_top;
  import tclb_pkg::*;
  import console_scoreboard_pkg::*;

  // 1300 items, with read waits and sender gaps mixed in: well below this.
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 275;

  logic       clk;
  logic       rst       = 1'b1;
  logic       start     = 1'b0;
  logic [1:0] command   = CMD_NONE;
  logic [7:0] char_code = '0;
  logic [4:0] read_row  = '0;
  logic [6:0] read_col  = '0;
  logic       busy;
  logic       done;
  logic [7:0] cell_code;
  logic [4:0] cursor_row;
  logic [7:0] cursor_col;
  logic       dropped;

  console_scoreboard sb;
  int unsigned       cycle_count = 0;
  int unsigned       items_sent  = 0;
  int unsigned       idle_pct    = 0;

  text_console_line_buffer_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .char_code (char_code),
    .read_row  (read_row),
    .read_col  (read_col),
    .done      (done),
    .cell_code (cell_code),
    .cursor_row(cursor_row),
    .cursor_col(cursor_col),
    .dropped   (dropped)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Results cannot be held off: every done cycle is a transfer. Values read
  // here are the pre-edge ones, i.e. what the block showed during the cycle.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(cell_code, cursor_row, cursor_col, dropped);
  end

  // One command transfer. start stays high into the next call when there is
  // no gap, so it is never lowered and raised in the same step.
  task automatic issue(cmd_t cmd, logic [7:0] code, logic [4:0] rrow, logic [6:0] rcol);
    start     <= 1'b1;
    command   <= cmd;
    char_code <= code;
    read_row  <= rrow;
    read_col  <= rcol;
    do @(posedge clk); while (busy);
    sb.note_command(cmd, code, rrow, rcol);
    items_sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
    end
  endtask

  // Put with junk on the read fields, which the block must ignore.
  task automatic put(logic [7:0] code);
    issue(CMD_PUT, code, 5'($urandom), 7'($urandom));
  endtask

  task automatic read_at(logic [4:0] rrow, logic [6:0] rcol);
    issue(CMD_READ, 8'($urandom), rrow, rcol);
  endtask

  // Any byte but carriage return and line feed.
  function automatic logic [7:0] glyph();
    logic [7:0] c;
    c = 8'($urandom);
    if (c == CODE_LF || c == CODE_CR) c = c ^ 8'h80;
    return c;
  endfunction

  // Hold the sender off until the block has answered everything.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic type_line(int unsigned len);
    repeat (len) put(glyph());
    if ($urandom_range(0, 1)) put(CODE_CR);
    put(CODE_LF);
  endtask

  // Mostly well-formed text (lines, then reads of what was typed), with
  // scroll runs, clears, the unused code and raw byte noise mixed in.
  task automatic random_phase(int unsigned target);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    logic [4:0]  rrow;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // long lines run past the last column to hit the full-row drop
        len = ($urandom_range(0, 99) < 6) ? $urandom_range(120, 135) : $urandom_range(0, 12);
        type_line(len);
      end else if (pick < 62) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1)) begin
            // near the cursor, mostly inside the written part of the row
            rrow = sb.cur_line[4:0];
            read_at(rrow, 7'($urandom_range(0, sb.cur_col + 2)));
          end else if ($urandom_range(0, 3) != 0) begin
            read_at(5'($urandom), 7'($urandom_range(0, 15)));
          end else begin
            read_at(5'($urandom), 7'($urandom));
          end
        end
      end else if (pick < 66) begin
        // enough line feeds to reach the bottom and scroll
        repeat ($urandom_range(20, 35)) begin
          if ($urandom_range(0, 99) < 30) put(glyph());
          put(CODE_LF);
        end
      end else if (pick < 68) begin
        issue(CMD_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
      end else if (pick < 73) begin
        issue(CMD_NONE, 8'($urandom), 5'($urandom), 7'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 7))
            0:       put(CODE_CR);
            1:       put(CODE_LF);
            default: put(8'($urandom));
          endcase
        end
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty screen, extremes of every field, CR ignored, zero and
    // 0xFF glyphs, read beyond row length, newline, clear, unused command.
    idle_pct = 0;
    read_at(5'd0, 7'd0);
    issue(CMD_NONE, 8'hFF, 5'd31, 7'd127);
    put(8'h41);
    put(8'hFF);
    put(8'h00);
    put(CODE_CR);
    read_at(5'd0, 7'd0);
    read_at(5'd0, 7'd1);
    read_at(5'd0, 7'd2);
    read_at(5'd0, 7'd3);
    read_at(5'd31, 7'd127);
    put(CODE_LF);
    put(8'h78);
    read_at(5'd1, 7'd0);
    read_at(5'd0, 7'd2);
    issue(CMD_CLEAR, 8'hFF, 5'd31, 7'd127);
    read_at(5'd0, 7'd0);
    read_at(5'd1, 7'd0);
    issue(CMD_NONE, 8'h00, 5'd0, 7'd0);
    drain();

    // A full row with drops, then enough line feeds to scroll several times.
    type_line(132);
    read_at(5'd1, 7'd127);
    repeat (34) put(CODE_LF);
    read_at(5'd30, 7'd0);
    read_at(5'd0, 7'd0);

    // Idle phases: none, sender 57 %, sender 30 %, none again. Each ends
    // with the sender paused until all results are in.
    random_phase(PHASE_ITEMS);
    drain();
    idle_pct = 57;
    random_phase(PHASE_ITEMS);
    drain();
    idle_pct = 30;
    random_phase(PHASE_ITEMS);
    drain();
    idle_pct = 0;
    random_phase(PHASE_ITEMS);

    drain();
    repeat (5) @(posedge clk);
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
